// File: hdl/gdo_pkg.sv
// shared constants, types and reciprocal factors for the date offset pipeline
package gdo_pkg;

  localparam int OFFSET_WIDTH_DEF = 21;

  // pipeline depths of the conversion units
  localparam int FWD_LAT   = 2;
  localparam int INV_LAT   = 7;
  localparam int TOTAL_LAT = FWD_LAT + 2 * INV_LAT + 1;

  // configuration register indexes
  localparam logic [1:0] CFG_DEFAULT_MONTH = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_DAY   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_YEAR  = 2'd2;

  localparam logic [3:0]  RST_DEFAULT_MONTH = 4'd5;
  localparam logic [4:0]  RST_DEFAULT_DAY   = 5'd11;
  localparam logic [13:0] RST_DEFAULT_YEAR  = 14'd1959;

  // day numbers of 1/1/1 and 12/31/9999
  localparam int JDN_MIN = 1721426;
  localparam int JDN_MAX = 5373484;

  // forward conversion constants
  localparam int Y_BIAS_A  = 4800;
  localparam int Y_BIAS_B  = 4900;
  localparam int DAYS_4Y   = 1461;
  localparam int JD_BIAS   = 32075;

  // inverse conversion constants
  localparam int L_BIAS    = 68569;
  localparam int DAYS_400Y = 146097;
  localparam int MON_BASE  = 31;
  localparam int CENT_BIAS = 4900;

  // floor(x * c / d) as (x * K) >> S, exact while x < 2**S / d
  localparam int C_S  = 22;
  localparam logic [15:0] C_K = 16'(((64'd1 << C_S) + 64'd99) / 64'd100);
  localparam int T2_S = 8;
  localparam logic [12:0] T2_K = 13'(((64'd367 << T2_S) + 64'd11) / 64'd12);
  localparam int N_S  = 42;
  localparam logic [26:0] N_K = 27'(((64'd4 << N_S) + 64'd146096) / 64'd146097);
  localparam int I_S  = 37;
  localparam logic [28:0] I_K = 29'(((64'd4000 << I_S) + 64'd1461000) / 64'd1461001);
  localparam int J_S  = 21;
  localparam logic [16:0] J_K = 17'(((64'd80 << J_S) + 64'd2446) / 64'd2447);
  localparam int DJ_S = 12;
  localparam logic [16:0] DJ_K = 17'(((64'd2447 << DJ_S) + 64'd79) / 64'd80);

  // date as it leaves the inverse conversion, wide enough to hold any stray value
  typedef struct packed {
    logic signed [6:0]  month;
    logic signed [10:0] day;
    logic signed [16:0] year;
  } date_wide_t;

endpackage

// File: hdl/gdo_fwd.sv
// date to day number conversion, two pipeline stages
module gdo_fwd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [13:0] year,
  output logic        out_valid,
  output logic [22:0] out_jd
);

  logic        early;
  logic [14:0] w1, w2;
  logic [24:0] p1;
  logic [30:0] pq;
  logic [3:0]  t;
  logic [16:0] p2;

  logic        v1_r, v2_r;
  logic [22:0] s1_t1_r;
  logic [7:0]  s1_q_r;
  logic [8:0]  s1_t2_r;
  logic [4:0]  s1_d_r;
  logic [22:0] jd_r;

  logic [9:0]  t3;
  logic [23:0] jd_nxt;

  // january and february count as months 13 and 14 of the year before
  always_comb begin
    early = (month < 4'd3);
    w1 = 15'(year) + (early ? 15'(gdo_pkg::Y_BIAS_A - 1) : 15'(gdo_pkg::Y_BIAS_A));
    w2 = 15'(year) + (early ? 15'(gdo_pkg::Y_BIAS_B - 1) : 15'(gdo_pkg::Y_BIAS_B));
    p1 = 25'(w1) * 25'(gdo_pkg::DAYS_4Y);
    pq = 31'(w2) * 31'(gdo_pkg::C_K);
    t  = early ? (month + 4'd10) : (month - 4'd2);
    p2 = 17'(t) * 17'(gdo_pkg::T2_K);
  end

  always_comb begin
    t3 = (10'(s1_q_r) * 10'd3) >> 2;
    jd_nxt = 24'(s1_t1_r) + 24'(s1_t2_r) + 24'(s1_d_r) - 24'(t3)
           - 24'(gdo_pkg::JD_BIAS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_t1_r <= p1[24:2];
    s1_q_r  <= pq[gdo_pkg::C_S +: 8];
    s1_t2_r <= p2[gdo_pkg::T2_S +: 9];
    s1_d_r  <= day;
    jd_r    <= jd_nxt[22:0];
  end

  assign out_valid = v2_r;
  assign out_jd    = jd_r;

endmodule

// File: hdl/gdo_inv.sv
// day number to date conversion, seven pipeline stages
module gdo_inv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [22:0]          in_jd,
  output logic                 out_valid,
  output gdo_pkg::date_wide_t  out_date
);

  localparam int LAST = gdo_pkg::INV_LAT - 1;

  logic [gdo_pkg::INV_LAT-1:0] v_r;

  logic [23:0] s1_l_r;
  logic [23:0] s2_l_r;
  logic [8:0]  s2_n_r;
  logic [15:0] s3_l2_r;
  logic [8:0]  s3_n_r;
  logic [15:0] s4_l2_r;
  logic [8:0]  s4_n_r;
  logic [6:0]  s4_i_r;
  logic [8:0]  s5_l3_r;
  logic [8:0]  s5_n_r;
  logic [6:0]  s5_i_r;
  logic [8:0]  s6_l3_r;
  logic [8:0]  s6_n_r;
  logic [6:0]  s6_i_r;
  logic [4:0]  s6_j_r;
  gdo_pkg::date_wide_t date_r;

  logic [50:0] pn;
  logic [26:0] p400;
  logic [23:0] l2;
  logic [15:0] yv;
  logic [44:0] pi;
  logic [17:0] p4y;
  logic [16:0] l3;
  logic [25:0] pj;
  logic [21:0] pdj;
  logic        k;
  logic [15:0] yr_sum;
  gdo_pkg::date_wide_t date_nxt;

  always_comb begin
    pn   = 51'(s1_l_r) * 51'(gdo_pkg::N_K);
    p400 = 27'(s2_n_r) * 27'(gdo_pkg::DAYS_400Y) + 27'd3;
    l2   = s2_l_r - 24'(p400[26:2]);
    yv   = s3_l2_r + 16'd1;
    pi   = 45'(yv) * 45'(gdo_pkg::I_K);
    p4y  = 18'(s4_i_r) * 18'(gdo_pkg::DAYS_4Y);
    l3   = 17'(s4_l2_r) - 17'(p4y[17:2]) + 17'(gdo_pkg::MON_BASE);
    pj   = 26'(s5_l3_r) * 26'(gdo_pkg::J_K);
    pdj  = 22'(s6_j_r) * 22'(gdo_pkg::DJ_K);
    // month index runs march..february, eleven and up roll into the next year
    k    = (s6_j_r >= 5'd11);
    yr_sum = 16'(s6_n_r) * 16'd100 + 16'(s6_i_r) + 16'(k);
    date_nxt.day   = $signed({2'b00, s6_l3_r}) - $signed({1'b0, pdj[gdo_pkg::DJ_S +: 10]});
    date_nxt.month = $signed({2'b00, s6_j_r}) + 7'sd2 - (k ? 7'sd12 : 7'sd0);
    date_nxt.year  = $signed({1'b0, yr_sum}) - 17'(gdo_pkg::CENT_BIAS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[gdo_pkg::INV_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_l_r  <= 24'(in_jd) + 24'(gdo_pkg::L_BIAS);
    s2_l_r  <= s1_l_r;
    s2_n_r  <= pn[gdo_pkg::N_S +: 9];
    s3_l2_r <= l2[15:0];
    s3_n_r  <= s2_n_r;
    s4_l2_r <= s3_l2_r;
    s4_n_r  <= s3_n_r;
    s4_i_r  <= pi[gdo_pkg::I_S +: 7];
    s5_l3_r <= l3[8:0];
    s5_n_r  <= s4_n_r;
    s5_i_r  <= s4_i_r;
    s6_l3_r <= s5_l3_r;
    s6_n_r  <= s5_n_r;
    s6_i_r  <= s5_i_r;
    s6_j_r  <= pj[gdo_pkg::J_S +: 5];
    date_r  <= date_nxt;
  end

  assign out_valid = v_r[LAST];
  assign out_date  = date_r;

endmodule

// File: hdl/gregorian_date_day_offset_top.sv
// top level: date check, default substitution, offset add and reconversion
//
// Fully pipelined: a request is taken in every cycle (busy stays low) and its
// result is on the out_ ports with out_valid high for one cycle only; the
// receiver cannot stall. The pipeline has two stages of date to day number
// conversion, seven stages of day number to date conversion for the round-trip
// check, one stage for default select, offset add and clamp, and seven more for
// the final conversion, each inverse stage holding at most one multiplier but
// the last, which holds two.
// Default date registers must only be written while no request is in flight.
module gregorian_date_day_offset_top #(
  parameter int OFFSET_WIDTH = gdo_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     in_month,
  input  logic [4:0]                     in_day,
  input  logic [13:0]                    in_year,
  input  logic signed [OFFSET_WIDTH-1:0] in_day_offset,
  output logic                           out_valid,
  output logic [3:0]                     out_month,
  output logic [4:0]                     out_day,
  output logic [13:0]                    out_year,
  output logic [22:0]                    out_base_day_number,
  output logic                           out_date_was_valid,
  output logic                           out_range_error,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [13:0]                    cfg_data
);

  localparam int D1    = gdo_pkg::FWD_LAT + gdo_pkg::INV_LAT;
  localparam int D2    = gdo_pkg::INV_LAT;
  localparam int SUM_W = ((OFFSET_WIDTH > 24) ? OFFSET_WIDTH : 24) + 1;

  logic [3:0]  dflt_month_r;
  logic [4:0]  dflt_day_r;
  logic [13:0] dflt_year_r;

  logic        acc;
  logic        fa_valid, fb_valid, ia_valid, ib_valid;
  logic [22:0] fa_jd, fb_jd;
  gdo_pkg::date_wide_t ia_date, ib_date;

  // request fields travel beside the check conversion
  logic [3:0]              m_d_r   [D1];
  logic [4:0]              d_d_r   [D1];
  logic [13:0]             y_d_r   [D1];
  logic [OFFSET_WIDTH-1:0] off_d_r [D1];
  logic [22:0]             jda_d_r [D2];

  logic              sel_v_r;
  logic [22:0]       sel_sum_r;
  logic [22:0]       sel_jd_r;
  logic              sel_ok_r;
  logic              sel_rerr_r;
  logic [22:0]       jd_d_r   [D2];
  logic              ok_d_r   [D2];
  logic              rerr_d_r [D2];

  logic                    ok;
  logic [22:0]             jd_sel;
  logic signed [SUM_W-1:0] sum;
  logic [22:0]             sum_nxt;
  logic                    rerr_nxt;

  // pipeline takes a request every cycle
  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_month_r <= gdo_pkg::RST_DEFAULT_MONTH;
      dflt_day_r   <= gdo_pkg::RST_DEFAULT_DAY;
      dflt_year_r  <= gdo_pkg::RST_DEFAULT_YEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        gdo_pkg::CFG_DEFAULT_MONTH: dflt_month_r <= cfg_data[3:0];
        gdo_pkg::CFG_DEFAULT_DAY:   dflt_day_r   <= cfg_data[4:0];
        gdo_pkg::CFG_DEFAULT_YEAR:  dflt_year_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  gdo_fwd u_fwd_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .month     (in_month),
    .day       (in_day),
    .year      (in_year),
    .out_valid (fa_valid),
    .out_jd    (fa_jd)
  );

  // free-running conversion of the default date, settles after a write once the new value has passed both fwd stages
  gdo_fwd u_fwd_dflt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (1'b1),
    .month     (dflt_month_r),
    .day       (dflt_day_r),
    .year      (dflt_year_r),
    .out_valid (fb_valid),
    .out_jd    (fb_jd)
  );

  gdo_inv u_inv_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fa_valid),
    .in_jd     (fa_jd),
    .out_valid (ia_valid),
    .out_date  (ia_date)
  );

  always_ff @(posedge clk) begin
    m_d_r[0]   <= in_month;
    d_d_r[0]   <= in_day;
    y_d_r[0]   <= in_year;
    off_d_r[0] <= in_day_offset;
    for (int s = 1; s < D1; s++) begin
      m_d_r[s]   <= m_d_r[s-1];
      d_d_r[s]   <= d_d_r[s-1];
      y_d_r[s]   <= y_d_r[s-1];
      off_d_r[s] <= off_d_r[s-1];
    end
    jda_d_r[0] <= fa_jd;
    for (int s = 1; s < D2; s++) begin
      jda_d_r[s] <= jda_d_r[s-1];
    end
  end

  // round-trip check, default select, offset add and clamp
  always_comb begin
    ok = (ia_date.month == $signed({3'b000, m_d_r[D1-1]}))
      && (ia_date.day   == $signed({6'b000000, d_d_r[D1-1]}))
      && (ia_date.year  == $signed({3'b000, y_d_r[D1-1]}));
    jd_sel = ok ? jda_d_r[D2-1] : fb_jd;
    sum = $signed({{(SUM_W-23){1'b0}}, jd_sel}) + SUM_W'($signed(off_d_r[D1-1]));
    if (sum < $signed(SUM_W'(gdo_pkg::JDN_MIN))) begin
      sum_nxt  = 23'(gdo_pkg::JDN_MIN);
      rerr_nxt = 1'b1;
    end else if (sum > $signed(SUM_W'(gdo_pkg::JDN_MAX))) begin
      sum_nxt  = 23'(gdo_pkg::JDN_MAX);
      rerr_nxt = 1'b1;
    end else begin
      sum_nxt  = sum[22:0];
      rerr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
    end else begin
      sel_v_r <= ia_valid;
    end
  end

  always_ff @(posedge clk) begin
    sel_sum_r  <= sum_nxt;
    sel_jd_r   <= jd_sel;
    sel_ok_r   <= ok;
    sel_rerr_r <= rerr_nxt;
    jd_d_r[0]   <= sel_jd_r;
    ok_d_r[0]   <= sel_ok_r;
    rerr_d_r[0] <= sel_rerr_r;
    for (int s = 1; s < D2; s++) begin
      jd_d_r[s]   <= jd_d_r[s-1];
      ok_d_r[s]   <= ok_d_r[s-1];
      rerr_d_r[s] <= rerr_d_r[s-1];
    end
  end

  gdo_inv u_inv_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sel_v_r),
    .in_jd     (sel_sum_r),
    .out_valid (ib_valid),
    .out_date  (ib_date)
  );

  assign out_valid           = ib_valid;
  assign out_month           = ib_date.month[3:0];
  assign out_day             = ib_date.day[4:0];
  assign out_year            = ib_date.year[13:0];
  assign out_base_day_number = jd_d_r[D2-1];
  assign out_date_was_valid  = ok_d_r[D2-1];
  assign out_range_error     = rerr_d_r[D2-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##(gdo_pkg::TOTAL_LAT) out_valid)
    else $error("request did not produce a result at fixed latency");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year >= 14'd1 && out_year <= 14'd9999
                   && out_month >= 4'd1 && out_month <= 4'd12
                   && out_day >= 5'd1))
    else $error("result date out of range");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      ((out_year == 14'd1 && out_month == 4'd1 && out_day == 5'd1)
       || (out_year == 14'd9999 && out_month == 4'd12 && out_day == 5'd31)))
    else $error("range error without saturated date");

  a_dflt_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ia_valid |-> fb_valid)
    else $error("default date conversion not settled at select");
`endif

endmodule
